// ----- sv/modulated_multitap_chorus_top_assert.svh -----
// Assertion macros for the chorus block.
`ifndef MODULATED_MULTITAP_CHORUS_TOP_ASSERT_SVH
`define MODULATED_MULTITAP_CHORUS_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MMC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("chorus: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("chorus: next-cycle check failed");

`endif

// ----- sv/mmc_pkg.sv -----
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared types and fixed widths of the modulated multitap chorus.
// ----------------------------------------------------------------------------
`default_nettype none
package mmc_pkg;
	localparam int SAMPLE_W = 32;
	localparam int GAIN_W   = 16;
	localparam int OFF_W    = 13;
	localparam int IDX_W    = 16;
	localparam int PER_W    = 17;
	localparam int LEN_W    = 14;
	localparam int VCNT_W   = 3;
	localparam int VSEL_W   = 3;
	localparam int CMD_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int ACC_W    = 52;
	localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;

	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TABLE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_VOICE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IN_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOICES   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 2'd3;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_TAPS  = 7'b0000100,
		ST_FIN1  = 7'b0001000,
		ST_FIN2  = 7'b0010000,
		ST_OUT   = 7'b0100000,
		ST_SPARE = 7'b1000000
	} state_t;
endpackage
`default_nettype wire

// ----- sv/mmc_ram.sv -----
// ----------------------------------------------------------------------------
// mmc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module mmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- sv/mmc_finish.sv -----
// ----------------------------------------------------------------------------
// mmc_finish
// Output gain, truncation toward zero and 24-bit clip, two stages.
// ----------------------------------------------------------------------------
`default_nettype none
module mmc_finish import mmc_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic signed [ACC_W-1:0]    acc,
	input  wire logic [GAIN_W-1:0]          gain,
	output logic                            done,
	output logic [SAMPLE_W-1:0]             result
);
	localparam int HI_W = ACC_W - 20;

	logic                       v_s1;
	logic                       neg_s1;
	logic [HI_W+GAIN_W-1:0]     hi_s1;
	logic [20+GAIN_W-1:0]       lo_s1;
	logic [ACC_W-1:0]           mag;
	logic [HI_W+GAIN_W:0]       sum;
	logic [HI_W+GAIN_W-15:0]    q;
	logic signed [23:0]         clip;

	assign mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start;
			done <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_s1 <= acc[ACC_W-1];
			hi_s1  <= mag[ACC_W-1:20] * gain;
			lo_s1  <= mag[19:0] * gain;
		end
		if (v_s1) begin
			result <= {clip, 8'd0};
		end
	end

	always_comb begin
		sum = (HI_W+GAIN_W+1)'(hi_s1) + (HI_W+GAIN_W+1)'(lo_s1 >> 20);
		q   = sum[HI_W+GAIN_W:15];
		if (neg_s1) begin
			clip = (q > (HI_W+GAIN_W-14)'(8388608)) ? -24'sd8388608 : 24'(-q);
		end else begin
			clip = (q > (HI_W+GAIN_W-14)'(8388607)) ? 24'sd8388607 : 24'(q);
		end
	end
endmodule
`default_nettype wire

// ----- sv/modulated_multitap_chorus_top.sv -----
// ----------------------------------------------------------------------------
// modulated_multitap_chorus_top
// Chorus: dry sample plus modulated delay-line taps, scaled and clipped.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | to block  | in_valid/in_ready   | command, sample_in, voice, table_index,
//          |           |                     | table_value, decay_value, period_value
//  out     | from block| out_valid/out_ready | sample_out
//  cfg     | to block  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  After reset the delay line is zeroed in a pass over all LINE_DEPTH
//  addresses; no request is taken then (cfg writes are). Table and voice
//  commands are taken in idle and leave the block idle. From the accept of a
//  sample request to its commit, one voice per cycle streams through table
//  read, line read, multiply and accumulate; the taps then drain, output gain
//  is applied in the finish block and the sample is committed. The next
//  request is taken in the cycle after commit while the result waits in the
//  output register; a stalled output holds the commit of the following sample.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modulated_multitap_chorus_top_assert.svh"
module modulated_multitap_chorus_top import mmc_pkg::*; #(
	parameter int MAX_VOICES  = 7,
	parameter int LINE_DEPTH  = 8192,
	parameter int TABLE_DEPTH = 65536
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [CMD_W-1:0]      command,
	input  wire logic [SAMPLE_W-1:0]   sample_in,
	input  wire logic [VSEL_W-1:0]     voice,
	input  wire logic [IDX_W-1:0]      table_index,
	input  wire logic [OFF_W-1:0]      table_value,
	input  wire logic [GAIN_W-1:0]     decay_value,
	input  wire logic [PER_W-1:0]      period_value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [SAMPLE_W-1:0]        sample_out,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [GAIN_W-1:0]     cfg_data
);
	localparam int LW = $clog2(LINE_DEPTH);
	localparam int TW = $clog2(TABLE_DEPTH);
	localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int MW = VW + TW;
	localparam int CW = (LW + 1 > OFF_W) ? LW + 1 : OFF_W;
	localparam int XW = 21;

	// configuration registers
	logic [GAIN_W-1:0] in_gain_q, out_gain_q;
	logic [VCNT_W-1:0] vcount_q;
	logic [LEN_W-1:0]  length_q;

	// per-voice state
	logic [TW-1:0]     phase_q  [MAX_VOICES];
	logic [GAIN_W-1:0] decay_q  [MAX_VOICES];
	logic [TW:0]       period_q [MAX_VOICES];

	state_t            state_q;
	logic [LW-1:0]     clr_q;
	logic [LW-1:0]     wp_q;
	logic [LW:0]       len_q;
	logic [VW:0]       nv_q, iss_q;
	logic [SAMPLE_W-1:0] samp_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [SAMPLE_W-1:0] res_q;

	// tap pipeline
	logic              v_s1, v_s2, v_s3;
	logic [VW-1:0]     vo_s1, vo_s2;
	logic signed [PROD_W-1:0] prod_s3;

	logic              in_acc, cmd_tbl_ok, cmd_voice_ok;
	logic [XW-1:0]     idx_x, per_x, vsel_x;
	logic [TW:0]       per_clamp;
	logic [LW:0]       len_next;
	logic [XW-1:0]     len_x;

	logic              mod_re;
	logic [MW-1:0]     mod_raddr, mod_waddr;
	logic [OFF_W-1:0]  mod_rdata;
	logic              line_we, line_re;
	logic [LW-1:0]     line_waddr, line_raddr;
	logic [SAMPLE_W-1:0] line_wdata, line_rdata;

	logic [CW-1:0]     off_c, len_c, wp_c, pos_c;
	logic              issue, commit, fin_done;
	logic [SAMPLE_W-1:0] fin_res;
	logic [VW:0]       nv_next;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;

	assign idx_x  = XW'(table_index);
	assign per_x  = XW'(period_value);
	assign vsel_x = XW'(voice);
	assign cmd_tbl_ok   = (vsel_x < XW'(MAX_VOICES)) && (idx_x < XW'(TABLE_DEPTH));
	assign cmd_voice_ok = (vsel_x < XW'(MAX_VOICES));

	always_comb begin
		if (per_x == '0) begin
			per_clamp = (TW+1)'(1);
		end else if (per_x > XW'(TABLE_DEPTH)) begin
			per_clamp = (TW+1)'(TABLE_DEPTH);
		end else begin
			per_clamp = per_x[TW:0];
		end
		// effective line length: zero acts as one, clamp at the depth
		len_x = XW'(length_q);
		if (len_x == '0) begin
			len_next = (LW+1)'(1);
		end else if (len_x > XW'(LINE_DEPTH)) begin
			len_next = (LW+1)'(LINE_DEPTH);
		end else begin
			len_next = len_x[LW:0];
		end
		nv_next = (4'(vcount_q) > 4'(MAX_VOICES)) ? (VW+1)'(MAX_VOICES) : (VW+1)'(vcount_q);
	end

	// ---- modulation table: one entry block per voice ----
	assign issue     = (state_q == ST_TAPS) && (iss_q < nv_q);
	assign mod_re    = issue;
	assign mod_raddr = {iss_q[VW-1:0], phase_q[iss_q[VW-1:0]]};
	assign mod_waddr = {voice[VW-1:0], idx_x[TW-1:0]};

	mmc_ram #(.WIDTH(OFF_W), .DEPTH(MAX_VOICES << TW), .AW(MW)) u_mod (
		.clk   (clk),
		.we    (in_acc && (command == CMD_TABLE) && cmd_tbl_ok),
		.waddr (mod_waddr),
		.wdata (table_value),
		.re    (mod_re),
		.raddr (mod_raddr),
		.rdata (mod_rdata)
	);

	// ---- tap position: clamp offset, wrap behind the write position ----
	always_comb begin
		off_c = CW'(mod_rdata);
		len_c = CW'(len_q);
		wp_c  = CW'(wp_q);
		if (off_c >= len_c) begin
			off_c = len_c - CW'(1);
		end
		pos_c = (wp_c >= off_c) ? (wp_c - off_c) : (wp_c + len_c - off_c);
	end

	assign commit     = (state_q == ST_OUT) && (!out_valid || out_ready);
	assign line_re    = v_s1;
	assign line_raddr = pos_c[LW-1:0];
	assign line_we    = (state_q == ST_CLEAR) || commit;
	assign line_waddr = (state_q == ST_CLEAR) ? clr_q : wp_q;
	assign line_wdata = (state_q == ST_CLEAR) ? '0 : samp_q;

	mmc_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH), .AW(LW)) u_line (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_waddr),
		.wdata (line_wdata),
		.re    (line_re),
		.raddr (line_raddr),
		.rdata (line_rdata)
	);

	mmc_finish u_fin (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_FIN1),
		.acc    (acc_q),
		.gain   (out_gain_q),
		.done   (fin_done),
		.result (fin_res)
	);

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_gain_q  <= GAIN_W'(32768);
			out_gain_q <= GAIN_W'(4096);
			vcount_q   <= '0;
			length_q   <= LEN_W'(8192);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IN_GAIN:  in_gain_q  <= cfg_data;
				REG_OUT_GAIN: out_gain_q <= cfg_data;
				REG_VOICES:   vcount_q   <= cfg_data[VCNT_W-1:0];
				REG_LENGTH:   length_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- sequencer and control state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			wp_q      <= '0;
			len_q     <= (LW+1)'(1);
			nv_q      <= '0;
			iss_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < MAX_VOICES; i++) begin
				phase_q[i]  <= '0;
				decay_q[i]  <= '0;
				period_q[i] <= (TW+1)'(1);
			end
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (commit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + LW'(1);
					if (clr_q == LW'(LINE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc && (command == CMD_VOICE) && cmd_voice_ok) begin
						decay_q[voice[VW-1:0]]  <= decay_value;
						period_q[voice[VW-1:0]] <= per_clamp;
						phase_q[voice[VW-1:0]]  <= '0;
					end
					if (in_acc && (command == CMD_SAMPLE)) begin
						len_q <= len_next;
						nv_q  <= nv_next;
						iss_q <= '0;
						// restart the line after a length decrease
						if ((LW+1)'(wp_q) >= len_next) begin
							wp_q <= '0;
						end
						state_q <= ST_TAPS;
					end
				end
				ST_TAPS: begin
					if (issue) begin
						iss_q <= iss_q + (VW+1)'(1);
					end else if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_FIN1;
					end
				end
				ST_FIN1: state_q <= ST_FIN2;
				ST_FIN2: begin
					if (fin_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (commit) begin
						wp_q <= ((LW+1)'(wp_q) + (LW+1)'(1) >= len_q) ? '0 : wp_q + LW'(1);
						for (int i = 0; i < MAX_VOICES; i++) begin
							phase_q[i] <= ((TW+1)'(phase_q[i]) + (TW+1)'(1) >= period_q[i])
								? '0 : phase_q[i] + TW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		vo_s1 <= iss_q[VW-1:0];
		vo_s2 <= vo_s1;
		if (v_s2) begin
			prod_s3 <= PROD_W'($signed(line_rdata) * $signed({1'b0, decay_q[vo_s2]}));
		end
		if (in_acc && (command == CMD_SAMPLE)) begin
			samp_q <= sample_in;
			acc_q  <= ACC_W'($signed(sample_in) * $signed({1'b0, in_gain_q}));
		end else if (v_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end
		if (fin_done) begin
			res_q <= fin_res;
		end
		if (commit) begin
			sample_out <= res_q;
		end
	end

	// ---- checks ----
	`MMC_ASSERT_NOW(a_taps_only_in_taps, v_s1 || v_s2 || v_s3, state_q == ST_TAPS)
	`MMC_ASSERT_NOW(a_issue_bound, state_q == ST_TAPS, iss_q <= nv_q)
	`MMC_ASSERT_NOW(a_fin_in_wait, fin_done, state_q == ST_FIN2)
	`MMC_ASSERT_NEXT(a_hold_commit, state_q == ST_OUT && out_valid && !out_ready,
		state_q == ST_OUT)
endmodule
`default_nettype wire
